// ----- hdl/triangle_fan_assembly_with_face_normal_core_macros.svh -----
// ----------------------------------------------------------------------------
// tfn assertion macros
// concurrent check helpers, removed when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FAN_ASSEMBLY_WITH_FACE_NORMAL_CORE_MACROS_SVH
`define TRIANGLE_FAN_ASSEMBLY_WITH_FACE_NORMAL_CORE_MACROS_SVH
`ifndef SYNTH
`define TFN_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tfn assertion failed");
`define TFN_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("tfn forbidden condition seen");
`else
`define TFN_ASSERT(lbl, prop)
`define TFN_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- hdl/tfn_pkg.sv -----
// ----------------------------------------------------------------------------
// tfn_pkg
// shared constants, types and helpers of the triangle fan core
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int IDX_W       = 17;
    localparam int STEP_W      = 6;

    localparam int FETCH_LAST  = 3;
    localparam int CROSS_LAST  = 6;
    localparam int SQ_LAST     = 3;
    localparam int SQRT_LAST   = 32;
    localparam int DIV_LAST    = 17;

    localparam logic [2:0] MODE_POS    = 3'd0;
    localparam logic [2:0] MODE_UV     = 3'd1;
    localparam logic [2:0] MODE_NRM    = 3'd2;
    localparam logic [2:0] MODE_CORNER = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    typedef struct packed {
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] t;
        logic [IDX_W-1:0] n;
    } t_corner;

    typedef struct packed {
        logic              take_en;
        logic              fetch_en;
        logic              edge_en;
        logic              cross_en;
        logic              abs_en;
        logic              scale_en;
        logic              sq_en;
        logic              sqrt_en;
        logic              div_en;
        logic              out_load;
        logic [1:0]        sel;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic tri_go;
        logic c_zero;
        logic scale_done;
        logic out_blocked;
    } t_sts;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        if (v > 32'sd32767) begin
            return 16'sd32767;
        end else if (v < -32'sd32768) begin
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

    function automatic logic idx_ok(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] cnt);
        return !idx[IDX_W-1] && (idx[IDX_W-2:0] < (IDX_W-1)'(cnt));
    endfunction

endpackage

// ----- hdl/tfn_ram.sv -----
// ----------------------------------------------------------------------------
// tfn_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tfn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- hdl/tfn_datapath.sv -----
// ----------------------------------------------------------------------------
// tfn_datapath
// tables, corner registers, face normal arithmetic and output word register
// ----------------------------------------------------------------------------
module tfn_datapath
    import tfn_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic [2:0]              i_mode,
    input  logic signed [31:0]      i_comp_a,
    input  logic signed [31:0]      i_comp_b,
    input  logic signed [31:0]      i_comp_c,
    input  logic signed [IDX_W-1:0] i_pos_index,
    input  logic signed [IDX_W-1:0] i_uv_index,
    input  logic signed [IDX_W-1:0] i_normal_index,
    input  logic                    i_face_last,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_pos_z,
    output logic signed [31:0]      o_tex_u,
    output logic signed [31:0]      o_tex_v,
    output logic signed [15:0]      o_norm_x,
    output logic signed [15:0]      o_norm_y,
    output logic signed [15:0]      o_norm_z,
    output logic                    o_last_of_triangle
);

    logic [CNT_W-1:0] r_pcnt, r_ucnt, r_ncnt;
    logic [1:0]       r_ccnt;
    t_corner          r_first, r_prev, r_c1, r_c2;
    t_corner          w_cur, w_rdc;

    logic             w_pwe, w_uwe, w_nwe, w_re;
    logic [95:0]      w_prd;
    logic [63:0]      w_urd;
    logic [47:0]      w_nrd;
    logic [2:0]       r_rv;
    logic             r_lat;
    logic [1:0]       r_rsel;

    logic signed [31:0] r_vpos [3][3];
    logic signed [31:0] r_vuv  [3][2];
    logic signed [15:0] r_vnrm [3][3];
    logic [2:0]         r_vnv;

    logic signed [32:0] w_e   [6];
    logic [32:0]        w_mag [6];
    logic [32:0]        w_sh  [6];
    logic [32:0]        w_mor;
    logic [1:0]         w_k;
    logic signed [30:0] r_e   [6];

    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod;
    logic signed [63:0] r_prod;
    logic               r_pv, r_psq;
    logic [2:0]         r_pk;
    logic signed [61:0] r_c [3];
    logic [60:0]        r_a [3];
    logic [2:0]         r_cneg;
    logic               r_czero;
    logic               w_hi, w_lo;
    logic [63:0]        r_s;

    logic [63:0]        r_rem, r_res, r_bit, w_t;
    logic [47:0]        r_drem, r_dvs;
    logic [15:0]        r_q, w_qc;
    logic signed [15:0] r_fn [3];

    assign w_cur = '{p: i_pos_index, t: i_uv_index, n: i_normal_index};

    assign w_pwe = i_cmd.take_en && (i_mode == MODE_POS) && (r_pcnt < CNT_W'(TABLE_DEPTH));
    assign w_uwe = i_cmd.take_en && (i_mode == MODE_UV) && (r_ucnt < CNT_W'(TABLE_DEPTH));
    assign w_nwe = i_cmd.take_en && (i_mode == MODE_NRM) && (r_ncnt < CNT_W'(TABLE_DEPTH));
    assign w_re  = i_cmd.fetch_en && (i_cmd.step < STEP_W'(FETCH_LAST));

    always_comb begin
        case (i_cmd.step[1:0])
            2'd0:    w_rdc = r_first;
            2'd1:    w_rdc = r_c1;
            default: w_rdc = r_c2;
        endcase
    end

    tfn_ram #(.WIDTH(96), .DEPTH(TABLE_DEPTH)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_pwe),
        .i_waddr (r_pcnt[ADDR_W-1:0]),
        .i_wdata ({i_comp_c, i_comp_b, i_comp_a}),
        .i_re    (w_re),
        .i_raddr (w_rdc.p[ADDR_W-1:0]),
        .o_rdata (w_prd)
    );

    tfn_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_uv_ram (
        .i_clk   (i_clk),
        .i_we    (w_uwe),
        .i_waddr (r_ucnt[ADDR_W-1:0]),
        .i_wdata ({i_comp_b, i_comp_a}),
        .i_re    (w_re),
        .i_raddr (w_rdc.t[ADDR_W-1:0]),
        .o_rdata (w_urd)
    );

    tfn_ram #(.WIDTH(48), .DEPTH(TABLE_DEPTH)) u_nrm_ram (
        .i_clk   (i_clk),
        .i_we    (w_nwe),
        .i_waddr (r_ncnt[ADDR_W-1:0]),
        .i_wdata ({sat16(i_comp_c), sat16(i_comp_b), sat16(i_comp_a)}),
        .i_re    (w_re),
        .i_raddr (w_rdc.n[ADDR_W-1:0]),
        .o_rdata (w_nrd)
    );

    // table counts and corner tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt  <= '0;
            r_ucnt  <= '0;
            r_ncnt  <= '0;
            r_ccnt  <= '0;
            r_first <= '0;
            r_prev  <= '0;
        end else if (i_cmd.take_en) begin
            case (i_mode)
                MODE_POS: begin
                    if (w_pwe) r_pcnt <= r_pcnt + 1'b1;
                end
                MODE_UV: begin
                    if (w_uwe) r_ucnt <= r_ucnt + 1'b1;
                end
                MODE_NRM: begin
                    if (w_nwe) r_ncnt <= r_ncnt + 1'b1;
                end
                MODE_CORNER: begin
                    if (r_ccnt == 2'd0) r_first <= w_cur;
                    r_prev <= w_cur;
                    if (i_face_last) begin
                        r_ccnt <= '0;
                    end else if (r_ccnt != 2'd2) begin
                        r_ccnt <= r_ccnt + 1'b1;
                    end
                end
                MODE_CLEAR: begin
                    r_pcnt <= '0;
                    r_ucnt <= '0;
                    r_ncnt <= '0;
                    r_ccnt <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_en && i_mode == MODE_CORNER && r_ccnt == 2'd2) begin
            r_c1 <= r_prev;
            r_c2 <= w_cur;
        end
    end

    // corner fetch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat <= 1'b0;
        end else begin
            r_lat <= w_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rsel <= i_cmd.step[1:0];
            r_rv   <= {idx_ok(w_rdc.n, r_ncnt), idx_ok(w_rdc.t, r_ucnt), idx_ok(w_rdc.p, r_pcnt)};
        end
        if (r_lat) begin
            for (int j = 0; j < 3; j++) begin
                r_vpos[r_rsel][j] <= r_rv[0] ? w_prd[32*j +: 32] : '0;
                r_vnrm[r_rsel][j] <= w_nrd[16*j +: 16];
            end
            for (int j = 0; j < 2; j++) begin
                r_vuv[r_rsel][j] <= r_rv[1] ? w_urd[32*j +: 32] : '0;
            end
            r_vnv[r_rsel] <= r_rv[2];
        end
    end

    // edges with common magnitude scaling
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_e[i]   = 33'(r_vpos[1][i]) - 33'(r_vpos[0][i]);
            w_e[i+3] = 33'(r_vpos[2][i]) - 33'(r_vpos[0][i]);
        end
        w_mor = '0;
        for (int i = 0; i < 6; i++) begin
            w_mag[i] = w_e[i][32] ? 33'(-w_e[i]) : 33'(w_e[i]);
            w_mor    = w_mor | w_mag[i];
        end
        if (w_mor[32]) begin
            w_k = 2'd3;
        end else if (w_mor[31]) begin
            w_k = 2'd2;
        end else if (w_mor[30]) begin
            w_k = 2'd1;
        end else begin
            w_k = 2'd0;
        end
        for (int i = 0; i < 6; i++) begin
            w_sh[i] = w_mag[i] >> w_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_en) begin
            for (int i = 0; i < 6; i++) begin
                r_e[i] <= w_e[i][32] ? -$signed(w_sh[i][30:0]) : $signed(w_sh[i][30:0]);
            end
        end
    end

    // shared multiplier, cross products then squares
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (i_cmd.sq_en) begin
            if (i_cmd.step < STEP_W'(SQ_LAST)) begin
                w_ma = $signed({1'b0, r_a[i_cmd.step[1:0]][30:0]});
                w_mb = w_ma;
            end
        end else begin
            case (i_cmd.step[2:0])
                3'd0: begin w_ma = 32'(r_e[1]); w_mb = 32'(r_e[5]); end
                3'd1: begin w_ma = 32'(r_e[2]); w_mb = 32'(r_e[4]); end
                3'd2: begin w_ma = 32'(r_e[2]); w_mb = 32'(r_e[3]); end
                3'd3: begin w_ma = 32'(r_e[0]); w_mb = 32'(r_e[5]); end
                3'd4: begin w_ma = 32'(r_e[0]); w_mb = 32'(r_e[4]); end
                3'd5: begin w_ma = 32'(r_e[1]); w_mb = 32'(r_e[3]); end
                default: begin w_ma = '0; w_mb = '0; end
            endcase
        end
    end

    assign w_prod = w_ma * w_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= (i_cmd.cross_en && i_cmd.step < STEP_W'(CROSS_LAST))
                 || (i_cmd.sq_en && i_cmd.step < STEP_W'(SQ_LAST));
        end
    end

    assign w_hi = |(r_a[0][60:31] | r_a[1][60:31] | r_a[2][60:31]);
    assign w_lo = r_a[0][30] | r_a[1][30] | r_a[2][30];

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_pk   <= i_cmd.step[2:0];
        r_psq  <= i_cmd.sq_en;
        if (i_cmd.edge_en) begin
            for (int i = 0; i < 3; i++) r_c[i] <= '0;
        end
        if (i_cmd.abs_en) begin
            r_s     <= '0;
            r_czero <= (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
            for (int i = 0; i < 3; i++) begin
                r_cneg[i] <= r_c[i][61];
                r_a[i]    <= r_c[i][61] ? 61'(-r_c[i]) : 61'(r_c[i]);
                r_fn[i]   <= '0;
            end
        end
        if (i_cmd.scale_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= w_hi ? (r_a[i] >> 1) : (r_a[i] << 1);
            end
        end
        if (r_pv) begin
            if (r_psq) begin
                r_s <= r_s + r_prod;
            end else if (r_pk[0]) begin
                r_c[r_pk[2:1]] <= r_c[r_pk[2:1]] - 62'(r_prod);
            end else begin
                r_c[r_pk[2:1]] <= r_c[r_pk[2:1]] + 62'(r_prod);
            end
        end
        if (i_cmd.div_en && i_cmd.step == STEP_W'(DIV_LAST)) begin
            r_fn[i_cmd.sel] <= r_cneg[i_cmd.sel] ? -$signed(w_qc) : $signed(w_qc);
        end
    end

    // square root, one result bit per cycle
    assign w_t = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_en) begin
            if (i_cmd.step == '0) begin
                r_rem <= r_s;
                r_res <= '0;
                r_bit <= 64'd1 << 62;
            end else begin
                if (r_rem >= w_t) begin
                    r_rem <= r_rem - w_t;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        end
    end

    // restoring divide, one quotient bit per cycle
    assign w_qc = (r_q > 16'd32767) ? 16'd32767 : r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_en) begin
            if (i_cmd.step == '0) begin
                r_drem <= 48'({r_a[i_cmd.sel][30:0], 14'd0}) + 48'(r_res[31:1]);
                r_dvs  <= {1'b0, r_res[31:0], 15'd0};
                r_q    <= '0;
            end else if (i_cmd.step < STEP_W'(DIV_LAST)) begin
                if (r_drem >= r_dvs) begin
                    r_drem <= r_drem - r_dvs;
                    r_q    <= {r_q[14:0], 1'b1};
                end else begin
                    r_q    <= {r_q[14:0], 1'b0};
                end
                r_dvs <= r_dvs >> 1;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_pos_x <= r_vpos[i_cmd.sel][0];
            o_pos_y <= r_vpos[i_cmd.sel][1];
            o_pos_z <= r_vpos[i_cmd.sel][2];
            o_tex_u <= r_vuv[i_cmd.sel][0];
            o_tex_v <= r_vuv[i_cmd.sel][1];
            o_norm_x <= r_vnv[i_cmd.sel] ? r_vnrm[i_cmd.sel][0] : r_fn[0];
            o_norm_y <= r_vnv[i_cmd.sel] ? r_vnrm[i_cmd.sel][1] : r_fn[1];
            o_norm_z <= r_vnv[i_cmd.sel] ? r_vnrm[i_cmd.sel][2] : r_fn[2];
            o_last_of_triangle <= (i_cmd.sel == 2'd2);
        end
    end

    assign o_sts.tri_go      = (i_mode == MODE_CORNER) && (r_ccnt == 2'd2);
    assign o_sts.c_zero      = r_czero;
    assign o_sts.scale_done  = !w_hi && w_lo;
    assign o_sts.out_blocked = o_valid && i_stall;

endmodule

// ----- hdl/tfn_ctrl.sv -----
// ----------------------------------------------------------------------------
// tfn_ctrl
// sequencer for corner fetch, normal computation and vertex output
// ----------------------------------------------------------------------------
`include "triangle_fan_assembly_with_face_normal_core_macros.svh"

module tfn_ctrl
    import tfn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output logic o_stall,
    output t_cmd o_cmd
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_FETCH = 10'b00_0000_0010,
        ST_EDGES = 10'b00_0000_0100,
        ST_CROSS = 10'b00_0000_1000,
        ST_ABS   = 10'b00_0001_0000,
        ST_SCALE = 10'b00_0010_0000,
        ST_SQSUM = 10'b00_0100_0000,
        ST_SQRT  = 10'b00_1000_0000,
        ST_DIV   = 10'b01_0000_0000,
        ST_EMIT  = 10'b10_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_sel, n_sel;

    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step + 1'b1;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.step = r_step;
        o_cmd.sel  = r_sel;
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (i_valid) begin
                    o_cmd.take_en = 1'b1;
                    if (i_sts.tri_go) n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.fetch_en = 1'b1;
                if (r_step == STEP_W'(FETCH_LAST)) n_state = ST_EDGES;
            end
            ST_EDGES: begin
                o_cmd.edge_en = 1'b1;
                n_step  = '0;
                n_state = ST_CROSS;
            end
            ST_CROSS: begin
                o_cmd.cross_en = 1'b1;
                if (r_step == STEP_W'(CROSS_LAST)) n_state = ST_ABS;
            end
            ST_ABS: begin
                o_cmd.abs_en = 1'b1;
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                n_step = '0;
                n_sel  = '0;
                if (i_sts.c_zero) begin
                    n_state = ST_EMIT;
                end else if (i_sts.scale_done) begin
                    n_state = ST_SQSUM;
                end else begin
                    o_cmd.scale_en = 1'b1;
                end
            end
            ST_SQSUM: begin
                o_cmd.sq_en = 1'b1;
                if (r_step == STEP_W'(SQ_LAST)) begin
                    n_step  = '0;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                o_cmd.sqrt_en = 1'b1;
                if (r_step == STEP_W'(SQRT_LAST)) begin
                    n_step  = '0;
                    n_sel   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_en = 1'b1;
                if (r_step == STEP_W'(DIV_LAST)) begin
                    n_step = '0;
                    if (r_sel == 2'd2) begin
                        n_sel   = '0;
                        n_state = ST_EMIT;
                    end else begin
                        n_sel = r_sel + 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                n_step = '0;
                if (!i_sts.out_blocked) begin
                    o_cmd.out_load = 1'b1;
                    if (r_sel == 2'd2) begin
                        n_sel   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_sel = r_sel + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_sel   <= n_sel;
        end
    end

    `TFN_ASSERT(a_load_free, o_cmd.out_load |-> !i_sts.out_blocked)
    `TFN_ASSERT(a_tri_fetch, (r_state == ST_IDLE && i_valid && i_sts.tri_go) |=> (r_state == ST_FETCH))
    `TFN_ASSERT_NEVER(a_step_range, r_step > STEP_W'(SQRT_LAST))

endmodule

// ----- hdl/triangle_fan_assembly_with_face_normal_core.sv -----
// ----------------------------------------------------------------------------
// triangle_fan_assembly_with_face_normal_core
// fan triangulation of polygon faces with table or computed flat normals
// ----------------------------------------------------------------------------
// One word is taken at a time. Table appends, clears and face corners that
// close no triangle are taken without raising o_stall. A corner that closes a
// triangle holds o_stall high, also through any output stall, for the table
// reads, the edges, the cross product through the shared multiplier, the
// magnitudes, the normalising shift, the sum of squares, the bit-serial square
// root and the three divides, then while the three vertex words leave through
// the output register. A zero cross product skips the root and the divides.
module triangle_fan_assembly_with_face_normal_core
    import tfn_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [2:0]              i_mode,
    input  logic signed [31:0]      i_comp_a,
    input  logic signed [31:0]      i_comp_b,
    input  logic signed [31:0]      i_comp_c,
    input  logic signed [IDX_W-1:0] i_pos_index,
    input  logic signed [IDX_W-1:0] i_uv_index,
    input  logic signed [IDX_W-1:0] i_normal_index,
    input  logic                    i_face_last,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_pos_z,
    output logic signed [31:0]      o_tex_u,
    output logic signed [31:0]      o_tex_v,
    output logic signed [15:0]      o_norm_x,
    output logic signed [15:0]      o_norm_y,
    output logic signed [15:0]      o_norm_z,
    output logic                    o_last_of_triangle
);

    t_cmd w_cmd;
    t_sts w_sts;

    tfn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_stall (o_stall),
        .o_cmd   (w_cmd)
    );

    tfn_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_mode             (i_mode),
        .i_comp_a           (i_comp_a),
        .i_comp_b           (i_comp_b),
        .i_comp_c           (i_comp_c),
        .i_pos_index        (i_pos_index),
        .i_uv_index         (i_uv_index),
        .i_normal_index     (i_normal_index),
        .i_face_last        (i_face_last),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_pos_x            (o_pos_x),
        .o_pos_y            (o_pos_y),
        .o_pos_z            (o_pos_z),
        .o_tex_u            (o_tex_u),
        .o_tex_v            (o_tex_v),
        .o_norm_x           (o_norm_x),
        .o_norm_y           (o_norm_y),
        .o_norm_z           (o_norm_z),
        .o_last_of_triangle (o_last_of_triangle)
    );

endmodule
